### rtl/sbx_pkg.sv
// ----------------------------------------------------------------------------
// sbx_pkg
// Shared constants and elaboration-time helpers for the SBX crossover block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbx_pkg;

  // default widths of the gene datapath
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DRAW_BITS_DEF   = 24;

  // spread exponent register, unsigned Q1.16
  localparam int              EXP_W     = 17;
  localparam logic [EXP_W-1:0] EXP_RESET = 17'd3121;

  // log2 fraction bits and normalized mantissa width (Q1.30)
  localparam int LOG_FRAC = 16;
  localparam int MANT_W   = 31;

  // spread factor: 24 fraction bits, capped at 2^33
  localparam int BETA_FRAC = 24;
  localparam int BETA_W    = 58;

  // magnitude cap of the spread term, 2^34 raw units
  localparam int T_W = 35;

  // floor integer square root, one result bit per step
  function automatic longint unsigned isqrt64(input longint unsigned val);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = val;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, k >= 1, built by repeated square roots
  function automatic logic [MANT_W-1:0] exp2_coef(input int k);
    longint unsigned c;
    c = isqrt64(64'd1 << 61);
    for (int j = 1; j < k; j++) begin
      c = isqrt64(c << 30);
    end
    return MANT_W'(c);
  endfunction

endpackage

`default_nettype wire

### rtl/sbx_if.sv
// ----------------------------------------------------------------------------
// sbx_if
// Valid/ready channels of the SBX crossover block: genes in, children out,
// and the exponent write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbx_gene_if #(
  parameter int VW = sbx_pkg::VALUE_WIDTH_DEF,
  parameter int DW = sbx_pkg::DRAW_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] parent_a;
  logic signed [VW-1:0] parent_b;
  logic [DW-1:0]        uniform_draw;
  logic                 last_in;

  modport source (output valid, parent_a, parent_b, uniform_draw, last_in, input ready);
  modport sink   (input valid, parent_a, parent_b, uniform_draw, last_in, output ready);
endinterface

interface sbx_child_if #(
  parameter int VW = sbx_pkg::VALUE_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] child_a;
  logic signed [VW-1:0] child_b;
  logic                 last_out;

  modport source (output valid, child_a, child_b, last_out, input ready);
  modport sink   (input valid, child_a, child_b, last_out, output ready);
endinterface

interface sbx_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [sbx_pkg::EXP_W-1:0]  spread_exponent;

  modport source (output valid, spread_exponent, input ready);
  modport sink   (input valid, spread_exponent, output ready);
endinterface

`default_nettype wire

### rtl/sbx_crossover_gene.sv
// ----------------------------------------------------------------------------
// sbx_crossover_gene
// Simulated binary crossover of one gene per beat: two Q16.16 parents and a
// uniform draw in, two saturated children out.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  gene_in    in   valid/ready    parent_a, parent_b, uniform_draw, last_in
//  child_out  out  valid/ready    child_a, child_b, last_out
//  cfg        in   valid/ready    spread_exponent (ready always high)
//
//  One gene per cycle sustained while the output buffer has room; the depth is
//  set by the one-bit-per-stage divider and the 16 squaring and 16 exp2
//  multiply stages.
//  Synchronous active-high reset clears valid bits and sets the exponent to
//  3121. All stages hold together while the two-entry output buffer is full;
//  gene_in.ready depends only on that buffer's fill.
// ----------------------------------------------------------------------------
`default_nettype none

module sbx_crossover_gene #(
  parameter int VALUE_WIDTH = sbx_pkg::VALUE_WIDTH_DEF,
  parameter int DRAW_BITS   = sbx_pkg::DRAW_BITS_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  sbx_gene_if.sink    gene_in,
  sbx_child_if.source child_out,
  sbx_cfg_if.sink     cfg
);
  import sbx_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int DW     = DRAW_BITS;
  localparam int QW     = 2 * DW;
  localparam int DIV_SW = (VW + 1) + VW + 1 + 1 + 1 + DW;
  localparam int POW_SW = (VW + 1) + VW + 1 + 1;
  localparam int LO_W   = VW + 8;
  localparam int HI_W   = 26 + VW;
  localparam int TT_W   = ((VW + 8 > 34) ? VW + 8 : 34) + 1;
  localparam int SUM_W  = ((VW + 1 > T_W + 1) ? VW + 1 : T_W + 1) + 1;

  // ---- exponent register
  logic [EXP_W-1:0] expo;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expo <= EXP_RESET;
    end else if (cfg.valid) begin
      expo <= cfg.spread_exponent;
    end
  end

  // ---- pipeline enable from the output buffer fill
  logic [1:0] cnt;
  logic       en;
  assign en            = (cnt != 2'd2);
  assign gene_in.ready = en;

  // ---- input stage
  logic                 s0_val;
  logic signed [VW-1:0] s0_a;
  logic signed [VW-1:0] s0_b;
  logic [DW-1:0]        s0_u;
  logic                 s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_val <= 1'b0;
    end else if (en) begin
      s0_val <= gene_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_a    <= gene_in.parent_a;
      s0_b    <= gene_in.parent_b;
      s0_u    <= gene_in.uniform_draw;
      s0_last <= gene_in.last_in;
    end
  end

  // sum, difference magnitude, divisor
  logic signed [VW:0] s0_s;
  logic signed [VW:0] s0_d;
  logic [VW:0]        s0_dn;
  logic [VW-1:0]      s0_dm;
  logic [DW:0]        s0_v;
  logic               s0_small;
  assign s0_s     = {s0_a[VW-1], s0_a} + {s0_b[VW-1], s0_b};
  assign s0_d     = {s0_a[VW-1], s0_a} - {s0_b[VW-1], s0_b};
  assign s0_dn    = -s0_d;
  assign s0_dm    = s0_d[VW] ? s0_dn[VW-1:0] : s0_d[VW-1:0];
  assign s0_v     = (DW+1)'(1) << DW;
  assign s0_small = !s0_u[DW-1];

  // ---- reciprocal branch divider
  logic              dv_val;
  logic [QW-1:0]     dv_q;
  logic [DIV_SW-1:0] dv_side;
  logic [DW:0]       dv_divisor;
  assign dv_divisor = s0_v - {1'b0, s0_u};

  sbx_div #(
    .DW (DW),
    .SW (DIV_SW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_val),
    .divisor   (dv_divisor),
    .side_in   ({s0_s, s0_dm, s0_d[VW], s0_last, s0_small, s0_u}),
    .out_valid (dv_val),
    .quotient  (dv_q),
    .side_out  (dv_side)
  );

  // x = 2u on the lower half, quotient otherwise
  logic [DW-1:0] dv_u;
  logic          dv_small;
  logic [QW-1:0] x;
  assign dv_u     = dv_side[DW-1:0];
  assign dv_small = dv_side[DW];
  assign x        = dv_small ? QW'({dv_u, 1'b0}) : dv_q;

  // ---- power unit
  logic              pw_val;
  logic [BETA_W-1:0] pw_beta;
  logic [POW_SW-1:0] pw_side;

  sbx_pow #(
    .DW (DW),
    .SW (POW_SW)
  ) u_pow (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_val),
    .x         (x),
    .expo      (expo),
    .side_in   (dv_side[DIV_SW-1:DW+1]),
    .out_valid (pw_val),
    .beta      (pw_beta),
    .side_out  (pw_side)
  );

  logic signed [VW:0] pw_s;
  logic [VW-1:0]      pw_dm;
  logic               pw_neg;
  logic               pw_last;
  assign {pw_s, pw_dm, pw_neg, pw_last} = pw_side;

  // ---- P1: low beta word times |a-b|
  logic [31+VW+1-1:0] lo_prod;
  assign lo_prod = pw_beta[31:0] * pw_dm;

  logic               p1_val;
  logic [LO_W-1:0]    p1_lo;
  logic [25:0]        p1_bhi;
  logic [VW-1:0]      p1_dm;
  logic signed [VW:0] p1_s;
  logic               p1_neg;
  logic               p1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_val <= 1'b0;
    end else if (en) begin
      p1_val <= pw_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_lo   <= lo_prod[VW+31:BETA_FRAC];
      p1_bhi  <= pw_beta[BETA_W-1:32];
      p1_dm   <= pw_dm;
      p1_s    <= pw_s;
      p1_neg  <= pw_neg;
      p1_last <= pw_last;
    end
  end

  // ---- P2: high beta word times |a-b|
  logic [HI_W-1:0] hi_prod;
  assign hi_prod = p1_bhi * p1_dm;

  logic               p2_val;
  logic               p2_big;
  logic [25:0]        p2_hi;
  logic [LO_W-1:0]    p2_lo;
  logic signed [VW:0] p2_s;
  logic               p2_neg;
  logic               p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_val <= 1'b0;
    end else if (en) begin
      p2_val <= p1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_big  <= (hi_prod[HI_W-1:26] != '0);
      p2_hi   <= hi_prod[25:0];
      p2_lo   <= p1_lo;
      p2_s    <= p1_s;
      p2_neg  <= p1_neg;
      p2_last <= p1_last;
    end
  end

  // ---- P3: spread term magnitude, capped at 2^34
  localparam logic [TT_W-1:0] T_CAP_TT = TT_W'(1) << (T_W - 1);
  logic [TT_W-1:0] tt;
  assign tt = TT_W'({p2_hi, 8'b0}) + TT_W'(p2_lo);

  logic               p3_val;
  logic [T_W-1:0]     p3_t;
  logic signed [VW:0] p3_s;
  logic               p3_neg;
  logic               p3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_val <= 1'b0;
    end else if (en) begin
      p3_val <= p2_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_t    <= (p2_big || tt > T_CAP_TT) ? T_CAP_TT[T_W-1:0] : tt[T_W-1:0];
      p3_s    <= p2_s;
      p3_neg  <= p2_neg;
      p3_last <= p2_last;
    end
  end

  // ---- P4: children, floor half, saturate
  logic signed [SUM_W-1:0] se;
  logic signed [SUM_W-1:0] te;
  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_b;
  logic signed [SUM_W-1:0] half_a;
  logic signed [SUM_W-1:0] half_b;
  logic signed [VW-1:0]    ca;
  logic signed [VW-1:0]    cb;
  localparam logic [VW-1:0] SAT_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] SAT_MIN = {1'b1, {(VW-1){1'b0}}};

  assign se     = SUM_W'(p3_s);
  assign te     = p3_neg ? -$signed(SUM_W'(p3_t)) : $signed(SUM_W'(p3_t));
  assign sum_a  = se + te;
  assign sum_b  = se - te;
  assign half_a = sum_a >>> 1;
  assign half_b = sum_b >>> 1;

  always_comb begin
    if (half_a[SUM_W-1:VW-1] == '0 || half_a[SUM_W-1:VW-1] == '1) begin
      ca = half_a[VW-1:0];
    end else begin
      ca = half_a[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
    if (half_b[SUM_W-1:VW-1] == '0 || half_b[SUM_W-1:VW-1] == '1) begin
      cb = half_b[VW-1:0];
    end else begin
      cb = half_b[SUM_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  // ---- two-entry output buffer
  logic [2*VW:0] buf0;
  logic [2*VW:0] buf1;
  logic [2*VW:0] buf0_next;
  logic [2*VW:0] buf1_next;
  logic [1:0]    cnt_next;
  logic          push;
  logic          pop;

  assign push = en && p3_val;
  assign pop  = (cnt != 2'd0) && child_out.ready;

  always_comb begin
    buf0_next = buf0;
    buf1_next = buf1;
    cnt_next  = cnt;
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) buf0_next = {ca, cb, p3_last};
        else buf1_next = {ca, cb, p3_last};
        cnt_next = cnt + 2'd1;
      end
      2'b01: begin
        buf0_next = buf1;
        cnt_next  = cnt - 2'd1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          buf0_next = {ca, cb, p3_last};
        end else begin
          buf0_next = buf1;
          buf1_next = {ca, cb, p3_last};
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    buf0 <= buf0_next;
    buf1 <= buf1_next;
  end

  assign child_out.valid    = (cnt != 2'd0);
  assign child_out.child_a  = buf0[2*VW:VW+1];
  assign child_out.child_b  = buf0[VW:1];
  assign child_out.last_out = buf0[0];

  // buffer never overfills
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output buffer overfilled");

  // a full buffer that is not drained stays full and holds the pipeline
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2) && !child_out.ready |=> (cnt == 2'd2) && !gene_in.ready)
    else $error("full buffer lost an entry");

  // spread term magnitude within its cap
  a_t_cap: assert property (@(posedge clk) disable iff (rst)
    p3_val |-> (TT_W'(p3_t) <= T_CAP_TT))
    else $error("spread term above cap");

endmodule

`default_nettype wire

### rtl/sbx_div.sv
// ----------------------------------------------------------------------------
// sbx_div
// Pipelined restoring divider: q = floor(2^(2*DW-1) / v), one quotient bit
// per stage, side data carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module sbx_div #(
  parameter int DW = sbx_pkg::DRAW_BITS_DEF,
  parameter int SW = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [DW:0]     divisor,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [2*DW-1:0]      quotient,
  output logic [SW-1:0]        side_out
);
  localparam int QW = 2 * DW;

  logic            val  [QW+1];
  logic [DW:0]     dvs  [QW+1];
  logic [DW-1:0]   rem  [QW+1];
  logic [QW-1:0]   quo  [QW+1];
  logic [SW-1:0]   side [QW+1];

  assign val[0]  = in_valid;
  assign dvs[0]  = divisor;
  assign rem[0]  = '0;
  assign quo[0]  = '0;
  assign side[0] = side_in;

  // one quotient bit per stage; the dividend has its only set bit on top
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW:0] rs;
    logic [DW:0] diff;
    logic        ge;

    assign rs   = {rem[i], (i == 0) ? 1'b1 : 1'b0};
    assign ge   = (rs >= dvs[i]);
    assign diff = rs - dvs[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        val[i+1] <= 1'b0;
      end else if (en) begin
        val[i+1] <= val[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? diff[DW-1:0] : rs[DW-1:0];
        quo[i+1]  <= {quo[i][QW-2:0], ge};
        dvs[i+1]  <= dvs[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = val[QW];
  assign quotient  = quo[QW];
  assign side_out  = side[QW];

  // remainder always below the divisor
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    val[QW] && (dvs[QW] != '0) |-> ({1'b0, rem[QW]} < dvs[QW]))
    else $error("divider remainder not below divisor");

  // a nonzero divisor of at most half the draw range gives a quotient of 2^DW or more
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    val[QW] && (dvs[QW] != '0) && (dvs[QW] <= (DW+1)'(1 << (DW - 1)))
      |-> (quo[QW][QW-1:DW] != '0))
    else $error("divider quotient out of range");

  // a held pipeline keeps its last stage
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(val[QW]) && $stable(quo[QW]))
    else $error("divider moved while held");

endmodule

`default_nettype wire

### rtl/sbx_pow.sv
// ----------------------------------------------------------------------------
// sbx_pow
// Spread factor beta = x^e through log2 (16 squaring stages), one multiply
// by the exponent, and exp2 (16 conditional constant multiply stages).
// ----------------------------------------------------------------------------
`default_nettype none

module sbx_pow #(
  parameter int DW = sbx_pkg::DRAW_BITS_DEF,
  parameter int SW = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [2*DW-1:0]             x,
  input  wire logic [sbx_pkg::EXP_W-1:0]   expo,
  input  wire logic [SW-1:0]               side_in,
  output logic                             out_valid,
  output logic [sbx_pkg::BETA_W-1:0]       beta,
  output logic [SW-1:0]                    side_out
);
  import sbx_pkg::*;

  localparam int QW   = 2 * DW;
  localparam int PW   = $clog2(QW);
  localparam int LG_W = PW + 1 + LOG_FRAC;
  localparam int Y_W  = LG_W + EXP_W + 1;
  localparam int YI_W = Y_W - 32;
  localparam int NS   = LOG_FRAC;
  localparam int SH_CAP  = 27;
  localparam int SH_ZERO = -40;
  localparam int SH_BIAS = 30 - BETA_FRAC;

  // ---- stage 1: leading one search
  logic [PW-1:0] msb;
  always_comb begin
    msb = '0;
    for (int j = 0; j < QW; j++) begin
      if (x[j]) msb = PW'(j);
    end
  end

  logic          s1_val;
  logic [QW-1:0] s1_x;
  logic [PW-1:0] s1_p;
  logic          s1_xz;
  logic [SW-1:0] s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_val <= 1'b0;
    end else if (en) begin
      s1_val <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x    <= x;
      s1_p    <= msb;
      s1_xz   <= (x == '0);
      s1_side <= side_in;
    end
  end

  // ---- stage 2: normalize mantissa to Q1.30
  logic [QW+MANT_W-1:0] xw;
  logic [PW-1:0]        lsh;
  assign lsh = PW'(QW - 1) - s1_p;
  assign xw  = {s1_x, {MANT_W{1'b0}}} << lsh;

  logic              sq_val  [NS+1];
  logic [MANT_W-1:0] sq_m    [NS+1];
  logic [NS-1:0]     sq_frac [NS+1];
  logic [PW-1:0]     sq_p    [NS+1];
  logic              sq_xz   [NS+1];
  logic [SW-1:0]     sq_side [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_val[0] <= 1'b0;
    end else if (en) begin
      sq_val[0] <= s1_val;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_m[0]    <= xw[QW+MANT_W-1 -: MANT_W];
      sq_frac[0] <= '0;
      sq_p[0]    <= s1_p;
      sq_xz[0]   <= s1_xz;
      sq_side[0] <= s1_side;
    end
  end

  // ---- squaring stages: one log2 fraction bit each
  for (genvar k = 0; k < NS; k++) begin : g_sq
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     sq;
    assign prod = sq_m[k] * sq_m[k];
    assign sq   = prod[2*MANT_W-1 -: MANT_W+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_val[k+1] <= 1'b0;
      end else if (en) begin
        sq_val[k+1] <= sq_val[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_m[k+1]    <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        sq_frac[k+1] <= {sq_frac[k][NS-2:0], sq[MANT_W]};
        sq_p[k+1]    <= sq_p[k];
        sq_xz[k+1]   <= sq_xz[k];
        sq_side[k+1] <= sq_side[k];
      end
    end
  end

  // ---- y = log2(x) * e, 32 fraction bits
  logic signed [PW:0]     lgi;
  logic signed [LG_W-1:0] lg;
  logic signed [Y_W-1:0]  y;
  assign lgi = $signed({1'b0, sq_p[NS]}) - $signed((PW+1)'(DW));
  assign lg  = {lgi, sq_frac[NS]};
  assign y   = lg * $signed({1'b0, expo});

  logic              ex_val  [NS+1];
  logic [MANT_W-1:0] ex_r    [NS+1];
  logic [NS-1:0]     ex_f    [NS+1];
  logic [YI_W-1:0]   ex_yi   [NS+1];
  logic              ex_xz   [NS+1];
  logic [SW-1:0]     ex_side [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_val[0] <= 1'b0;
    end else if (en) begin
      ex_val[0] <= sq_val[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0]    <= MANT_W'(1) << 30;
      ex_f[0]    <= y[31:16];
      ex_yi[0]   <= y[Y_W-1:32];
      ex_xz[0]   <= sq_xz[NS];
      ex_side[0] <= sq_side[NS];
    end
  end

  // ---- exp2 stages: multiply by 2^(2^-(k+1)) where that fraction bit is set
  for (genvar k = 0; k < NS; k++) begin : g_ex
    localparam logic [MANT_W-1:0] COEF = exp2_coef(k + 1);
    logic [2*MANT_W-1:0] prod;
    assign prod = ex_r[k] * COEF;

    always_ff @(posedge clk) begin
      if (rst) begin
        ex_val[k+1] <= 1'b0;
      end else if (en) begin
        ex_val[k+1] <= ex_val[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ex_r[k+1]    <= ex_f[k][NS-1-k] ? prod[MANT_W+29:30] : ex_r[k];
        ex_f[k+1]    <= ex_f[k];
        ex_yi[k+1]   <= ex_yi[k];
        ex_xz[k+1]   <= ex_xz[k];
        ex_side[k+1] <= ex_side[k];
      end
    end
  end

  // ---- scale by the integer part, cap, special cases
  logic signed [YI_W:0] sh;
  logic [YI_W:0]        nsh;
  logic [BETA_W-1:0]    rext;
  logic [BETA_W-1:0]    beta_next;
  assign sh   = $signed({ex_yi[NS][YI_W-1], ex_yi[NS]}) - $signed((YI_W+1)'(SH_BIAS));
  assign nsh  = -sh;
  assign rext = BETA_W'(ex_r[NS]);

  always_comb begin
    if (expo == '0) begin
      beta_next = BETA_W'(1) << BETA_FRAC;
    end else if (ex_xz[NS]) begin
      beta_next = '0;
    end else if (sh >= SH_CAP) begin
      beta_next = BETA_W'(1) << (BETA_W - 1);
    end else if (sh >= 0) begin
      beta_next = rext << sh[4:0];
    end else if (sh <= SH_ZERO) begin
      beta_next = '0;
    end else begin
      beta_next = rext >> nsh[5:0];
    end
  end

  logic vb;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= ex_val[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beta     <= beta_next;
      side_out <= ex_side[NS];
    end
  end

  assign out_valid = vb;

  // normalized mantissa keeps its leading one for a nonzero x
  a_norm: assert property (@(posedge clk) disable iff (rst)
    sq_val[0] && !sq_xz[0] |-> sq_m[0][MANT_W-1])
    else $error("mantissa not normalized");

  // exp2 result stays in [1, 2)
  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    ex_val[NS] |-> ex_r[NS][MANT_W-1] && !$isunknown(ex_r[NS]))
    else $error("exp2 result out of range");

  // beta never exceeds its cap
  a_beta_cap: assert property (@(posedge clk) disable iff (rst)
    vb |-> (beta <= (BETA_W'(1) << (BETA_W - 1))))
    else $error("beta above cap");

endmodule

`default_nettype wire
